>>> design/length_prefixed_crc16_framer_assert.svh
// assertion macros for the length-prefixed crc-16 framer
// expects clk and rst_n in scope of the module that includes this file
`ifndef LENGTH_PREFIXED_CRC16_FRAMER_ASSERT_SVH
`define LENGTH_PREFIXED_CRC16_FRAMER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define LPCF_ASSERT_NOW(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("framer assertion failed");

// next-cycle implication, disabled while in reset
`define LPCF_ASSERT_NEXT(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("framer assertion failed");

`endif

>>> design/lpcf_pkg.sv
// shared types, constants and the crc-16 byte fold for the framer
// no dependencies
`default_nettype none

package lpcf_pkg;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 16;
    localparam int CRC_W       = 16;
    localparam int MAX_RESULTS = 5;
    localparam int CNT_W       = 3;

    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
    localparam logic [CRC_W-1:0] CRC_TOP  = 16'h8000;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_DATA  = 1'b1;

    typedef struct packed {
        logic [MAX_RESULTS-1:0][BYTE_W-1:0] bytes;
        logic [CNT_W-1:0]                   count;
        logic                               done;
        logic                               err;
    } lpcf_group_t;

    function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < BYTE_W; k++)
        begin
            if ((c & CRC_TOP) != '0)
                c = (c << 1) ^ CRC_POLY;
            else
                c = c << 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> design/lpcf_engine.sv
// frame state (crc, bytes left, open flag) and result group builder
// depends on lpcf_pkg
`default_nettype none

module lpcf_engine (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire logic                        kind,
    input  wire logic [lpcf_pkg::LEN_W-1:0]  frame_length,
    input  wire logic [lpcf_pkg::BYTE_W-1:0] data_byte,
    input  wire logic [lpcf_pkg::BYTE_W-1:0] command_code,
    output lpcf_pkg::lpcf_group_t            group
);
    import lpcf_pkg::*;

    logic [CRC_W-1:0] crc_reg, crc_next;
    logic [LEN_W-1:0] left_reg, left_next;
    logic             open_reg, open_next;
    logic [CRC_W-1:0] crc_fold_val;
    logic [LEN_W-1:0] left_dec;
    logic             len_zero;
    logic             dec_zero;

    assign crc_fold_val = crc_fold(crc_reg, data_byte);
    assign left_dec     = left_reg - LEN_W'(1);
    assign len_zero     = (frame_length == '0);
    assign dec_zero     = (left_dec == '0);

    always_comb
    begin
        crc_next  = crc_reg;
        left_next = left_reg;
        open_next = open_reg;
        group     = '0;
        case (kind)
            KIND_START:
            begin
                crc_next        = CRC_INIT;
                left_next       = frame_length;
                open_next       = !len_zero;
                group.bytes[0]  = command_code;
                group.bytes[1]  = frame_length[15:8];
                group.bytes[2]  = frame_length[7:0];
                group.bytes[3]  = CRC_INIT[15:8];
                group.bytes[4]  = CRC_INIT[7:0];
                group.count     = len_zero ? CNT_W'(5) : CNT_W'(3);
                group.done      = len_zero;
            end
            KIND_DATA:
            begin
                if (!open_reg)
                begin
                    group.count = CNT_W'(1);
                    group.err   = 1'b1;
                end
                else
                begin
                    crc_next       = crc_fold_val;
                    left_next      = left_dec;
                    open_next      = !dec_zero;
                    group.bytes[0] = data_byte;
                    group.bytes[1] = crc_fold_val[15:8];
                    group.bytes[2] = crc_fold_val[7:0];
                    group.count    = dec_zero ? CNT_W'(3) : CNT_W'(1);
                    group.done     = dec_zero;
                end
            end
            default:
            begin
                group.count = CNT_W'(1);
                group.err   = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg  <= CRC_INIT;
            left_reg <= '0;
            open_reg <= 1'b0;
        end
        else if (accept)
        begin
            crc_reg  <= crc_next;
            left_reg <= left_next;
            open_reg <= open_next;
        end
    end

endmodule

`default_nettype wire

>>> design/length_prefixed_crc16_framer.sv
// latency: first byte of an item's output appears the cycle after the request is taken
// throughput: with m_tready high, an item's bytes leave one byte a cycle, and
// a frame's non-final data byte gives one byte, so one request per cycle is sustained
// the next request is taken in the cycle the last byte of the previous group leaves
// reset (rst_n low, asynchronous): output group emptied, crc to ffff, no frame open,
// command code to 0
`default_nettype none
`include "length_prefixed_crc16_framer_assert.svh"

module length_prefixed_crc16_framer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data,     // command_code
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,      // frame_length [15:0], data_byte [23:16]
    input  wire logic        s_tuser,      // kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,      // out_byte
    output logic             m_tlast,
    output logic [1:0]       m_tuser       // frame_done [0], error [1]
);
    import lpcf_pkg::*;

    logic [BYTE_W-1:0]                  cmd_reg;
    logic [MAX_RESULTS-1:0][BYTE_W-1:0] buf_reg, buf_next;
    logic [CNT_W-1:0]                   rem_reg, rem_next;
    logic                               done_reg, done_next;
    logic                               err_reg, err_next;
    logic                               take;
    logic                               accept;
    lpcf_group_t                        group;

    assign cfg_ready = 1'b1;

    assign m_tvalid = (rem_reg != '0);
    assign take     = m_tvalid && m_tready;
    assign s_tready = (rem_reg == '0) || (take && (rem_reg == CNT_W'(1)));
    assign accept   = s_tvalid && s_tready;

    assign m_tdata  = buf_reg[0];
    assign m_tlast  = (rem_reg == CNT_W'(1));
    assign m_tuser  = {err_reg, done_reg && m_tlast};

    lpcf_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .kind         (s_tuser),
        .frame_length (s_tdata[15:0]),
        .data_byte    (s_tdata[23:16]),
        .command_code (cmd_reg),
        .group        (group)
    );

    always_comb
    begin
        buf_next  = buf_reg;
        rem_next  = rem_reg;
        done_next = done_reg;
        err_next  = err_reg;
        if (accept)
        begin
            buf_next  = group.bytes;
            rem_next  = group.count;
            done_next = group.done;
            err_next  = group.err;
        end
        else if (take)
        begin
            buf_next = buf_reg >> BYTE_W;
            rem_next = rem_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg  <= '0;
            rem_reg  <= '0;
            done_reg <= 1'b0;
            err_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                cmd_reg <= cfg_data;
            rem_reg  <= rem_next;
            done_reg <= done_next;
            err_reg  <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

    `LPCF_ASSERT_NOW(a_accept_drains, accept && m_tvalid, m_tready && m_tlast)
    `LPCF_ASSERT_NOW(a_done_is_last, m_tvalid && m_tuser[0], m_tlast && !m_tuser[1])
    `LPCF_ASSERT_NOW(a_error_single, m_tvalid && m_tuser[1], m_tlast && (m_tdata == 8'h00))
    `LPCF_ASSERT_NEXT(a_accept_shows, accept, m_tvalid)
    `LPCF_ASSERT_NOW(a_count_range, m_tvalid, rem_reg <= CNT_W'(MAX_RESULTS))

endmodule

`default_nettype wire
